// ===== rtl/stq_pkg.sv =====
// Sorted timer queue: shared types, constants and codes.
// No dependencies; imported by stq_cell and sorted_timer_queue.
`default_nettype none

package stq_pkg;

  localparam int CAPACITY    = 16;
  localparam int TIME_BITS   = 32;
  localparam int MAX_RESULTS = 16;
  localparam int ID_BITS     = 10;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   id_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_RETIME = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_NONE_DUE  = 3'd4,
    ST_DUPLICATE = 3'd5
  } status_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY,
    S_TICK
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    id_t         timer_id;
    logic [31:0] new_expire;
    logic [31:0] current_time;
  } in_beat_t;

  typedef struct packed {
    status_t status;
    id_t     expired_id;
    logic    last;
  } out_beat_t;

  // contents of one cell
  typedef struct packed {
    logic  valid;
    id_t   handle;
    time_t expiry;
  } entry_t;

  // command and key broadcast from the controller
  typedef struct packed {
    cell_op_t op;
    id_t      id;
    time_t    expiry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/stq_cell.sv =====
// One slot of the sorted timer chain: holds an entry, flags match and order
// against the broadcast key, and moves data to or from its neighbours. Uses stq_pkg.
`default_nettype none

module stq_cell import stq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    prev,
  input  wire entry_t    next,
  input  wire logic      le_prev,
  input  wire logic      del_prev,
  output entry_t         cur,
  output logic           le_o,
  output logic           match_o,
  output logic           del_o
);

  logic  valid_r,  valid_nxt;
  id_t   handle_r, handle_nxt;
  time_t expiry_r, expiry_nxt;
  logic  le_r;
  logic  match_r;

  // flags against the held key, refreshed every cycle
  always_ff @(posedge clk) begin
    le_r    <= valid_r && (expiry_r <= ctl.expiry);
    match_r <= valid_r && (handle_r == ctl.id);
  end

  always_comb begin
    valid_nxt  = valid_r;
    handle_nxt = handle_r;
    expiry_nxt = expiry_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (!le_r) begin
          if (le_prev) begin
            valid_nxt  = 1'b1;
            handle_nxt = ctl.id;
            expiry_nxt = ctl.expiry;
          end else begin
            valid_nxt  = prev.valid;
            handle_nxt = prev.handle;
            expiry_nxt = prev.expiry;
          end
        end
      end
      OP_REMOVE: begin
        if (del_prev || match_r) begin
          valid_nxt  = next.valid;
          handle_nxt = next.handle;
          expiry_nxt = next.expiry;
        end
      end
      OP_SHIFT: begin
        valid_nxt  = next.valid;
        handle_nxt = next.handle;
        expiry_nxt = next.expiry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    expiry_r <= expiry_nxt;
  end

  assign cur     = '{valid: valid_r, handle: handle_r, expiry: expiry_r};
  assign le_o    = le_r;
  assign match_o = match_r;
  assign del_o   = del_prev | match_r;

endmodule

`default_nettype wire

// ===== rtl/sorted_timer_queue.sv =====
// Sorted timer queue top level: command sequencer, result register and the
// chain of stq_cell slots. Uses stq_pkg and stq_cell.
//
//   channel | direction | payload    | handshake
//   in_     | input     | in_beat_t  | in_valid / in_ready
//   out_    | output    | out_beat_t | out_valid / out_ready
//
// Add and delete step through accept, cell flag update and apply; re-time through
// accept, flag update, remove, a second flag update and insert; a tick is accepted,
// then the chain shifts out one expired entry a cycle unless a waiting result stalls it, up to
// MAX_RESULTS. Reset clears every cell's valid flag; the block is ready straight after.
// A result waiting in the output register holds the next apply or tick step;
// a new command is taken while the previous result still waits.
`default_nettype none

module sorted_timer_queue import stq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_beat_t     out_data
);

  state_t    state_r, state_nxt;
  cmd_t      cmd_r;
  id_t       id_r;
  time_t     exp_r;
  time_t     now_r;
  logic      ins_phase_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic      out_valid_r;
  out_beat_t out_data_r;

  entry_t    cells [CAPACITY];
  logic [CAPACITY-1:0] le_vec, match_vec, del_vec, valid_vec;

  cell_op_t  op;
  logic      emit;
  status_t   emit_status;
  id_t       emit_id;
  logic      emit_last;

  logic slot_free, found, full, exp0, exp1;

  assign slot_free = !out_valid_r || out_ready;
  assign found     = |match_vec;
  assign full      = cells[CAPACITY-1].valid;
  assign exp0      = cells[0].valid && (cells[0].expiry <= now_r);
  assign exp1      = cells[1].valid && (cells[1].expiry <= now_r);

  // cell chain
  cell_ctl_t ctl;
  assign ctl = '{op: op, id: id_r, expiry: exp_r};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   le_p, del_p;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign le_p   = 1'b1;
      assign del_p  = 1'b0;
    end else begin : g_body
      assign prev_e = cells[i-1];
      assign le_p   = le_vec[i-1];
      assign del_p  = del_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cells[i+1];
    end

    stq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev     (prev_e),
      .next     (next_e),
      .le_prev  (le_p),
      .del_prev (del_p),
      .cur      (cells[i]),
      .le_o     (le_vec[i]),
      .match_o  (match_vec[i]),
      .del_o    (del_vec[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    op          = OP_HOLD;
    emit        = 1'b0;
    emit_status = ST_DONE;
    emit_id     = '0;
    emit_last   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_LOOK: begin
      end
      S_APPLY: begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (slot_free) begin
              emit = 1'b1;
              if (found) begin
                emit_status = ST_DUPLICATE;
              end else if (full) begin
                emit_status = ST_FULL;
              end else begin
                op = OP_INSERT;
              end
            end
          end
          CMD_RETIME: begin
            if (ins_phase_r) begin
              if (slot_free) begin
                emit = 1'b1;
                op   = OP_INSERT;
              end
            end else if (found) begin
              op = OP_REMOVE;
            end else if (slot_free) begin
              emit        = 1'b1;
              emit_status = ST_NOT_FOUND;
            end
          end
          CMD_DELETE: begin
            if (slot_free) begin
              emit = 1'b1;
              if (found) begin
                op = OP_REMOVE;
              end else begin
                emit_status = ST_NOT_FOUND;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_TICK: begin
        if (slot_free) begin
          emit = 1'b1;
          if (exp0) begin
            op          = OP_SHIFT;
            emit_status = ST_EXPIRED;
            emit_id     = cells[0].handle;
            emit_last   = !exp1 || (cnt_r == CNT_BITS'(MAX_RESULTS - 1));
          end else begin
            emit_status = ST_NONE_DUE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.cmd == CMD_TICK) ? S_TICK : S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end else if (op == OP_REMOVE) begin
          state_nxt = S_LOOK;
        end
      end
      S_TICK: begin
        if (emit && emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ins_phase_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_valid && in_ready) begin
        ins_phase_r <= 1'b0;
        cnt_r       <= '0;
      end else begin
        if (state_r == S_APPLY && op == OP_REMOVE && !emit) begin
          ins_phase_r <= 1'b1;
        end
        if (state_r == S_TICK && emit) begin
          cnt_r <= cnt_r + CNT_BITS'(1);
        end
      end
    end
  end

  // command fields held for the whole operation
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data.cmd;
      id_r  <= in_data.timer_id;
      exp_r <= time_t'(in_data.new_expire);
      now_r <= time_t'(in_data.current_time);
    end
    if (emit) begin
      out_data_r <= '{status: emit_status, expired_id: emit_id, last: emit_last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // live entries always form a prefix of the chain
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & ~{valid_vec[CAPACITY-2:0], 1'b1}) == '0)
    else $error("hole in the timer chain");

  for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_chk
    assert property (@(posedge clk) disable iff (!rst_n)
      cells[j+1].valid |-> (cells[j].expiry <= cells[j+1].expiry))
      else $error("timer chain out of order");
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && cmd_r == CMD_ADD && emit && emit_status == ST_DONE)
    |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("add did not grow the queue by one");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && cmd_r == CMD_DELETE && emit && emit_status == ST_DONE)
    |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
    else $error("delete did not shrink the queue by one");

endmodule

`default_nettype wire
